// ===== hdl/tdr_pkg.sv =====
//------------------------------------------------------------------------------
// tdr_pkg
// Shared constants and types of the triangle depth rasterizer.
//------------------------------------------------------------------------------
package tdr_pkg;
    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int XW          = $clog2(MAX_WIDTH);
    localparam int YW          = $clog2(MAX_HEIGHT);
    localparam int AW          = XW + YW;
    localparam int DW          = 24;
    localparam int CW          = 17;
    localparam int EW          = 26;
    localparam int SW          = 52;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_TRI   = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FAR    = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [11:0] vertex0_x;
        logic signed [11:0] vertex0_y;
        logic [23:0]        vertex0_z;
        logic signed [11:0] vertex1_x;
        logic signed [11:0] vertex1_y;
        logic [23:0]        vertex1_z;
        logic signed [11:0] vertex2_x;
        logic signed [11:0] vertex2_y;
        logic [23:0]        vertex2_z;
    } t_in_item;

    typedef struct packed {
        logic [23:0] read_depth;
        logic [16:0] pixels_updated;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLEAR, ST_SETUP0, ST_SETUP1, ST_SETUP2, ST_WALK, ST_DIV,
        ST_RMW, ST_READ, ST_READW, ST_OUT
    } t_state;

    typedef struct packed {
        logic          start;
        logic [SW-1:0] dividend;
        logic [EW-1:0] divisor;
    } t_div_req;
endpackage

// ===== hdl/tdr_if.sv =====
//------------------------------------------------------------------------------
// tdr_if
// Valid/ready channel carrying one item.
//------------------------------------------------------------------------------
interface tdr_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/triangle_depth_rasterizer.sv =====
//------------------------------------------------------------------------------
// triangle_depth_rasterizer
// Half-space triangle rasterizer with a depth store in one synchronous RAM.
//------------------------------------------------------------------------------
// A clear item writes far depth to every store entry, one entry a cycle; the
// store needs no clearing pass after reset, since reset starts the same sweep
// and no item is taken until it ends. A triangle item passes through the setup
// states SETUP0, SETUP1 and SETUP2, then walks its clamped bounding box, stepping
// past pixels outside the triangle. For each covered pixel the depth quotient
// comes from a bit-serial divider and each pixel is a read, compare and write of
// the store.
module triangle_depth_rasterizer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    tdr_if.sink                  i_in,
    tdr_if.source                o_out,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [23:0]          i_cfg_data
);
    import tdr_pkg::*;

    logic [DW-1:0] mem [MAX_WIDTH*MAX_HEIGHT];
    logic [DW-1:0] r_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [DW-1:0] mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[mem_ra];
    end

    logic [8:0]  r_wid, r_hgt;
    logic [23:0] r_far;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wid <= 9'd256;
            r_hgt <= 9'd256;
            r_far <= 24'hFFFFFF;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WIDTH: r_wid <= i_cfg_data[8:0];
                REG_HEIGHT: r_hgt <= i_cfg_data[8:0];
                REG_FAR: r_far <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [12:0] eff_w, eff_h;
    always_comb begin
        eff_w = (r_wid == 9'd0) ? 13'd1 : 13'(r_wid);
        if (eff_w > 13'(MAX_WIDTH)) eff_w = 13'(MAX_WIDTH);
        eff_h = (r_hgt == 9'd0) ? 13'd1 : 13'(r_hgt);
        if (eff_h > 13'(MAX_HEIGHT)) eff_h = 13'(MAX_HEIGHT);
    end

    t_state r_st, n_st;
    t_in_item r_it;
    logic signed [12:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic [23:0] r_az, r_bz, r_cz;
    logic signed [EW-1:0] r_area;
    logic signed [13:0] r_minx, r_miny, r_maxx, r_maxy, r_px, r_py;
    logic signed [EW-1:0] r_w0, r_w1, r_w2, r_r0, r_r1, r_r2;
    logic signed [13:0] r_a0, r_a1, r_a2, r_b0, r_b1, r_b2;
    logic [AW:0]   r_clr;
    logic          r_boot;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_dep;
    logic [1:0]    r_mph;
    logic [SW-1:0] r_sum;
    logic          r_ov;
    t_out_item     r_out;

    t_div_req dreq;
    logic d_done;
    logic [DW-1:0] d_q;
    tdr_div u_div (.i_clk, .i_rst_n, .i_req(dreq), .o_done(d_done), .o_quot(d_q));

    function automatic logic signed [EW-1:0] edgef(
        input logic signed [12:0] ax, ay, bx, by, px, py);
        logic signed [EW-1:0] p1, p2;
        p1 = EW'(bx - ax) * EW'(py - ay);
        p2 = EW'(by - ay) * EW'(px - ax);
        return p1 - p2;
    endfunction

    function automatic logic signed [12:0] mn(input logic signed [12:0] a, b);
        return (a < b) ? a : b;
    endfunction
    function automatic logic signed [12:0] mx(input logic signed [12:0] a, b);
        return (a > b) ? a : b;
    endfunction

    logic inside_px, last_x, last_y;
    logic [49:0] prod;
    logic [23:0] mz;
    logic [EW-1:0] mw;
    always_comb begin
        inside_px = !r_w0[EW-1] && !r_w1[EW-1] && !r_w2[EW-1];
        last_x = (r_px == r_maxx);
        last_y = (r_py == r_maxy);
        case (r_mph)
            2'd0: begin mz = r_az; mw = r_w0; end
            2'd1: begin mz = r_bz; mw = r_w1; end
            default: begin mz = r_cz; mw = r_w2; end
        endcase
        prod = 50'(mz) * 50'(mw);
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: if (i_in.valid) begin
                case (i_in.data.kind)
                    KIND_CLEAR: n_st = ST_CLEAR;
                    KIND_TRI: n_st = ST_SETUP0;
                    KIND_READ: n_st = ST_READ;
                    default: n_st = ST_OUT;
                endcase
            end
            ST_CLEAR: if (r_clr[AW]) n_st = r_boot ? ST_IDLE : ST_OUT;
            ST_SETUP0: n_st = ST_SETUP1;
            ST_SETUP1: n_st = ST_SETUP2;
            ST_SETUP2: n_st = (r_area <= 0 || r_minx > r_maxx || r_miny > r_maxy)
                              ? ST_OUT : ST_WALK;
            ST_WALK: begin
                if (inside_px) begin
                    if (r_mph == 2'd3) n_st = ST_DIV;
                end else if (last_x && last_y) n_st = ST_OUT;
            end
            ST_DIV: if (d_done) n_st = ST_RMW;
            ST_RMW: n_st = (last_x && last_y) ? ST_OUT : ST_WALK;
            ST_READ: n_st = ST_READW;
            ST_READW: n_st = ST_OUT;
            ST_OUT: if (o_out.ready) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_py[YW-1:0] * AW'(MAX_WIDTH) + AW'(r_px[XW-1:0]);
        mem_wd = r_dep;
        mem_ra = mem_wa;
        if (r_st == ST_CLEAR) begin
            mem_we = !r_clr[AW];
            mem_wa = r_clr[AW-1:0];
            mem_wd = r_far;
        end else if (r_st == ST_RMW) begin
            mem_we = (r_dep <= r_rdata);
        end else if (r_st == ST_READ) begin
            mem_ra = r_it.vertex0_y[YW-1:0] * AW'(MAX_WIDTH) + AW'(r_it.vertex0_x[XW-1:0]);
        end
        dreq.start = (r_st == ST_WALK) && inside_px && r_mph == 2'd3;
        dreq.dividend = r_sum;
        dreq.divisor = r_area;
        i_in.ready = (r_st == ST_IDLE);
        o_out.valid = (r_st == ST_OUT);
        o_out.data = r_out;
    end

    logic signed [EW-1:0] e_ab;
    logic swap;
    always_comb begin
        e_ab = edgef(13'(r_it.vertex0_x), 13'(r_it.vertex0_y), 13'(r_it.vertex1_x),
                     13'(r_it.vertex1_y), 13'(r_it.vertex2_x), 13'(r_it.vertex2_y));
        swap = e_ab < 0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_CLEAR;
            r_clr <= '0;
            r_boot <= 1'b1;
            r_mph <= '0;
            r_it.kind <= KIND_CLEAR;
        end else begin
            r_st <= n_st;
            case (r_st)
                ST_IDLE: begin
                    r_it <= i_in.data;
                    r_clr <= '0;
                    r_cnt <= '0;
                    r_out <= '0;
                end
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr[AW]) r_boot <= 1'b0;
                end
                ST_SETUP0: begin
                    r_ax <= swap ? 13'(r_it.vertex1_x) : 13'(r_it.vertex0_x);
                    r_ay <= swap ? 13'(r_it.vertex1_y) : 13'(r_it.vertex0_y);
                    r_az <= swap ? r_it.vertex1_z : r_it.vertex0_z;
                    r_bx <= swap ? 13'(r_it.vertex0_x) : 13'(r_it.vertex1_x);
                    r_by <= swap ? 13'(r_it.vertex0_y) : 13'(r_it.vertex1_y);
                    r_bz <= swap ? r_it.vertex0_z : r_it.vertex1_z;
                    r_cx <= 13'(r_it.vertex2_x);
                    r_cy <= 13'(r_it.vertex2_y);
                    r_cz <= r_it.vertex2_z;
                    r_area <= swap ? -e_ab : e_ab;
                end
                ST_SETUP1: begin
                    r_minx <= mn(mn(r_ax, r_bx), r_cx) < 0 ? 14'sd0 : 14'(mn(mn(r_ax, r_bx), r_cx));
                    r_miny <= mn(mn(r_ay, r_by), r_cy) < 0 ? 14'sd0 : 14'(mn(mn(r_ay, r_by), r_cy));
                    r_maxx <= 14'(mx(mx(r_ax, r_bx), r_cx)) > $signed(14'(eff_w)) - 14'sd1
                              ? $signed(14'(eff_w)) - 14'sd1 : 14'(mx(mx(r_ax, r_bx), r_cx));
                    r_maxy <= 14'(mx(mx(r_ay, r_by), r_cy)) > $signed(14'(eff_h)) - 14'sd1
                              ? $signed(14'(eff_h)) - 14'sd1 : 14'(mx(mx(r_ay, r_by), r_cy));
                    r_a0 <= 14'(r_by - r_cy); r_b0 <= 14'(r_cx - r_bx);
                    r_a1 <= 14'(r_cy - r_ay); r_b1 <= 14'(r_ax - r_cx);
                    r_a2 <= 14'(r_ay - r_by); r_b2 <= 14'(r_bx - r_ax);
                end
                ST_SETUP2: begin
                    r_px <= r_minx;
                    r_py <= r_miny;
                    r_w0 <= edgef(r_bx, r_by, r_cx, r_cy, 13'(r_minx), 13'(r_miny));
                    r_w1 <= edgef(r_cx, r_cy, r_ax, r_ay, 13'(r_minx), 13'(r_miny));
                    r_w2 <= edgef(r_ax, r_ay, r_bx, r_by, 13'(r_minx), 13'(r_miny));
                    r_r0 <= edgef(r_bx, r_by, r_cx, r_cy, 13'(r_minx), 13'(r_miny));
                    r_r1 <= edgef(r_cx, r_cy, r_ax, r_ay, 13'(r_minx), 13'(r_miny));
                    r_r2 <= edgef(r_ax, r_ay, r_bx, r_by, 13'(r_minx), 13'(r_miny));
                    r_mph <= '0;
                    r_sum <= '0;
                    if (r_area <= 0 || r_minx > r_maxx || r_miny > r_maxy) r_out <= '0;
                end
                ST_WALK: begin
                    if (inside_px) begin
                        if (r_mph != 2'd3) begin
                            r_sum <= r_sum + SW'(prod);
                            r_mph <= r_mph + 2'd1;
                        end
                    end else if (!(last_x && last_y)) begin
                        if (last_x) begin
                            r_px <= r_minx; r_py <= r_py + 14'sd1;
                            r_w0 <= r_r0 + EW'(r_b0); r_r0 <= r_r0 + EW'(r_b0);
                            r_w1 <= r_r1 + EW'(r_b1); r_r1 <= r_r1 + EW'(r_b1);
                            r_w2 <= r_r2 + EW'(r_b2); r_r2 <= r_r2 + EW'(r_b2);
                        end else begin
                            r_px <= r_px + 14'sd1;
                            r_w0 <= r_w0 + EW'(r_a0);
                            r_w1 <= r_w1 + EW'(r_a1);
                            r_w2 <= r_w2 + EW'(r_a2);
                        end
                    end else begin
                        r_out.pixels_updated <= r_cnt;
                    end
                end
                ST_DIV: if (d_done) r_dep <= d_q;
                ST_RMW: begin
                    r_mph <= '0;
                    r_sum <= '0;
                    if (mem_we) begin
                        r_cnt <= r_cnt + 1'b1;
                        r_out.pixels_updated <= r_cnt + 1'b1;
                    end
                    if (!(last_x && last_y)) begin
                        if (last_x) begin
                            r_px <= r_minx; r_py <= r_py + 14'sd1;
                            r_w0 <= r_r0 + EW'(r_b0); r_r0 <= r_r0 + EW'(r_b0);
                            r_w1 <= r_r1 + EW'(r_b1); r_r1 <= r_r1 + EW'(r_b1);
                            r_w2 <= r_r2 + EW'(r_b2); r_r2 <= r_r2 + EW'(r_b2);
                        end else begin
                            r_px <= r_px + 14'sd1;
                            r_w0 <= r_w0 + EW'(r_a0);
                            r_w1 <= r_w1 + EW'(r_a1);
                            r_w2 <= r_w2 + EW'(r_a2);
                        end
                    end
                end
                ST_READ: r_ov <= r_it.vertex0_x < 0 || r_it.vertex0_y < 0
                               || 13'(r_it.vertex0_x) >= eff_w || 13'(r_it.vertex0_y) >= eff_h;
                ST_READW: r_out.read_depth <= r_ov ? '0 : r_rdata;
                default: ;
            endcase
        end
    end
endmodule

// ===== hdl/tdr_div.sv =====
//------------------------------------------------------------------------------
// tdr_div
// Restoring divider, one quotient bit per cycle.
//------------------------------------------------------------------------------
module tdr_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tdr_pkg::t_div_req    i_req,
    output logic                 o_done,
    output logic [tdr_pkg::DW-1:0] o_quot
);
    import tdr_pkg::*;

    logic [SW-1:0] r_q, n_q;
    logic [EW:0]   r_rem, n_rem;
    logic [EW-1:0] r_den;
    logic [5:0]    r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic [EW:0]   trial;

    always_comb begin
        n_q = r_q;
        n_rem = r_rem;
        n_cnt = r_cnt;
        n_busy = r_busy;
        trial = {r_rem[EW-1:0], r_q[SW-1]} - {1'b0, r_den};
        if (i_req.start) begin
            n_q = i_req.dividend;
            n_rem = '0;
            n_cnt = 6'(SW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!trial[EW]) begin
                n_rem = trial;
                n_q = {r_q[SW-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[EW-1:0], r_q[SW-1]};
                n_q = {r_q[SW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt <= n_cnt;
        end
        r_q <= n_q;
        r_rem <= n_rem;
        if (i_req.start) begin
            r_den <= i_req.divisor;
        end
    end

    assign o_done = r_busy && (r_cnt == 6'd1);
    assign o_quot = n_q[DW-1:0];
endmodule

// ===== dv/testbench.sv =====
//------------------------------------------------------------------------------
// testbench
// Drives clear, triangle and read items, and items of the unused kind, through
// the triangle depth rasterizer under random source gaps and sink stalls. An
// in-bench depth store model predicts each result, and every result is checked field by field.
//------------------------------------------------------------------------------
module testbench;
    import tdr_pkg::*;

    localparam longint CYCLE_LIMIT = 40_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [23:0] i_cfg_data;

    tdr_if #(.T(t_in_item))  in_ch();
    tdr_if #(.T(t_out_item)) out_ch();

    triangle_depth_rasterizer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    t_in_item  pending_items[$];
    t_out_item expected_results[$];
    logic [23:0] model_depth[MAX_WIDTH*MAX_HEIGHT];
    logic [8:0]  model_width;
    logic [8:0]  model_height;
    logic [23:0] model_far;
    int          error_count;
    longint      cycle_count;
    logic        in_accepted;
    int          burst_left;
    int          gap_left;
    logic [15:0] stall_lfsr;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint eff_width();
        if (model_width == 0) return 1;
        if (model_width > MAX_WIDTH) return MAX_WIDTH;
        return model_width;
    endfunction

    function automatic longint eff_height();
        if (model_height == 0) return 1;
        if (model_height > MAX_HEIGHT) return MAX_HEIGHT;
        return model_height;
    endfunction

    function automatic longint edge_value(longint ax, longint ay, longint bx, longint by,
                                          longint px, longint py);
        return (bx - ax) * (py - ay) - (by - ay) * (px - ax);
    endfunction

    function automatic t_out_item predict_depth_result(t_in_item it);
        t_out_item res;
        longint ax, ay, bx, by, cx, cy, tx, ty, area;
        longint minx, miny, maxx, maxy, w0, w1, w2;
        longint unsigned az, bz, cz, tz, total, d;
        int count;
        res = '0;
        count = 0;
        if (it.kind == KIND_CLEAR) begin
            foreach (model_depth[i]) model_depth[i] = model_far;
        end else if (it.kind == KIND_READ) begin
            ax = it.vertex0_x;
            ay = it.vertex0_y;
            if (ax >= 0 && ay >= 0 && ax < eff_width() && ay < eff_height())
                res.read_depth = model_depth[ay * MAX_WIDTH + ax];
        end else if (it.kind == KIND_TRI) begin
            ax = it.vertex0_x; ay = it.vertex0_y; az = it.vertex0_z;
            bx = it.vertex1_x; by = it.vertex1_y; bz = it.vertex1_z;
            cx = it.vertex2_x; cy = it.vertex2_y; cz = it.vertex2_z;
            if (edge_value(ax, ay, bx, by, cx, cy) < 0) begin
                tx = ax; ty = ay; tz = az;
                ax = bx; ay = by; az = bz;
                bx = tx; by = ty; bz = tz;
            end
            area = edge_value(ax, ay, bx, by, cx, cy);
            if (area > 0) begin
                minx = ax < bx ? ax : bx; minx = minx < cx ? minx : cx;
                miny = ay < by ? ay : by; miny = miny < cy ? miny : cy;
                maxx = ax > bx ? ax : bx; maxx = maxx > cx ? maxx : cx;
                maxy = ay > by ? ay : by; maxy = maxy > cy ? maxy : cy;
                if (minx < 0) minx = 0;
                if (miny < 0) miny = 0;
                if (maxx > eff_width() - 1) maxx = eff_width() - 1;
                if (maxy > eff_height() - 1) maxy = eff_height() - 1;
                for (longint py = miny; py <= maxy; py++) begin
                    for (longint px = minx; px <= maxx; px++) begin
                        w0 = edge_value(bx, by, cx, cy, px, py);
                        w1 = edge_value(cx, cy, ax, ay, px, py);
                        w2 = edge_value(ax, ay, bx, by, px, py);
                        if (w0 >= 0 && w1 >= 0 && w2 >= 0) begin
                            total = az * w0 + bz * w1 + cz * w2;
                            d = (total / area) & 24'hFFFFFF;
                            if (d <= model_depth[py * MAX_WIDTH + px]) begin
                                model_depth[py * MAX_WIDTH + px] = d[23:0];
                                count++;
                            end
                        end
                    end
                end
            end
            res.pixels_updated = count[16:0];
        end
        return res;
    endfunction

    // Clamped bounding-box size, used to keep random triangles cheap to draw.
    function automatic longint box_pixels(int x0, int y0, int x1, int y1, int x2, int y2);
        longint minx, miny, maxx, maxy;
        minx = x0 < x1 ? x0 : x1; minx = minx < x2 ? minx : x2;
        miny = y0 < y1 ? y0 : y1; miny = miny < y2 ? miny : y2;
        maxx = x0 > x1 ? x0 : x1; maxx = maxx > x2 ? maxx : x2;
        maxy = y0 > y1 ? y0 : y1; maxy = maxy > y2 ? maxy : y2;
        if (minx < 0) minx = 0;
        if (miny < 0) miny = 0;
        if (maxx > eff_width() - 1) maxx = eff_width() - 1;
        if (maxy > eff_height() - 1) maxy = eff_height() - 1;
        if (maxx < minx || maxy < miny) return 0;
        return (maxx - minx + 1) * (maxy - miny + 1);
    endfunction

    task automatic push_item(logic [1:0] kind, int x0, int y0, int z0, int x1, int y1,
                             int z1, int x2, int y2, int z2);
        t_in_item it;
        it.kind = kind;
        it.vertex0_x = x0; it.vertex0_y = y0; it.vertex0_z = z0;
        it.vertex1_x = x1; it.vertex1_y = y1; it.vertex1_z = z1;
        it.vertex2_x = x2; it.vertex2_y = y2; it.vertex2_z = z2;
        pending_items.push_back(it);
    endtask

    task automatic push_read(int x, int y);
        push_item(KIND_READ, x, y, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom);
    endtask

    task automatic push_random_item();
        int x0, y0, x1, y1, x2, y2, sel, tries;
        sel = $urandom_range(0, 99);
        if (sel < 38) begin
            if ($urandom_range(0, 3) == 0)
                push_read($urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048);
            else
                push_read($urandom_range(0, eff_width()), $urandom_range(0, eff_height()));
        end else if (sel < 40) begin
            push_item(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom);
        end else begin
            tries = 0;
            do begin
                if ($urandom_range(0, 3) == 0) begin
                    x0 = $urandom_range(0, 4095) - 2048; y0 = $urandom_range(0, 4095) - 2048;
                    x1 = $urandom_range(0, 4095) - 2048; y1 = $urandom_range(0, 4095) - 2048;
                    x2 = $urandom_range(0, 4095) - 2048; y2 = $urandom_range(0, 4095) - 2048;
                end else begin
                    x0 = $urandom_range(0, eff_width() + 8) - 4;
                    y0 = $urandom_range(0, eff_height() + 8) - 4;
                    x1 = x0 + $urandom_range(0, 8) - 4; y1 = y0 + $urandom_range(0, 8) - 4;
                    x2 = x0 + $urandom_range(0, 8) - 4; y2 = y0 + $urandom_range(0, 8) - 4;
                end
                tries++;
            end while (box_pixels(x0, y0, x1, y1, x2, y2) > 64 && tries < 40);
            if (tries >= 40) begin
                x0 = 1; y0 = 1; x1 = 4; y1 = 2; x2 = 2; y2 = 5;
            end
            push_item(KIND_TRI, x0, y0, $urandom, x1, y1, $urandom, x2, y2, $urandom);
        end
    endtask

    task automatic wait_idle();
        wait (pending_items.size() == 0 && expected_results.size() == 0 && !in_ch.valid);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [23:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        if (index == REG_WIDTH) model_width = value[8:0];
        else if (index == REG_HEIGHT) model_height = value[8:0];
        else if (index == REG_FAR) model_far = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            burst_left  <= 0;
            gap_left    <= 0;
        end else if (!in_ch.valid || in_accepted) begin
            if (gap_left > 0) begin
                gap_left    <= gap_left - 1;
                in_ch.valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                in_ch.data  <= pending_items.pop_front();
                in_ch.valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(0, 30);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        stall_lfsr <= {stall_lfsr[14:0], stall_lfsr[15] ^ stall_lfsr[13] ^ stall_lfsr[12]
                       ^ stall_lfsr[10]};
        if (cycle_count[12:11] == 2'd0)
            out_ch.ready <= 1'b1;
        else
            out_ch.ready <= stall_lfsr[0] | stall_lfsr[3];
    end

    always @(posedge i_clk) begin
        t_out_item want;
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            in_accepted <= 1'b0;
        end else begin
            in_accepted <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready)
                expected_results.push_back(predict_depth_result(in_ch.data));
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: read_depth %0d pixels_updated %0d",
                           out_ch.data.read_depth, out_ch.data.pixels_updated);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (out_ch.data.read_depth !== want.read_depth) begin
                        $error("read_depth expected %0d actual %0d",
                               want.read_depth, out_ch.data.read_depth);
                        error_count++;
                    end
                    if (out_ch.data.pixels_updated !== want.pixels_updated) begin
                        $error("pixels_updated expected %0d actual %0d",
                               want.pixels_updated, out_ch.data.pixels_updated);
                        error_count++;
                    end
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = REG_WIDTH;
        i_cfg_data   = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        stall_lfsr   = 16'hACE1;
        cycle_count  = 0;
        error_count  = 0;
        in_accepted  = 1'b0;
        model_width  = 256;
        model_height = 256;
        model_far    = 24'hFFFFFF;
        foreach (model_depth[i]) model_depth[i] = 24'hFFFFFF;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset contents, reads at and past the screen edges, and the unused kind.
        push_read(0, 0);
        push_read(255, 255);
        push_read(256, 0);
        push_read(-1, 5);
        push_read(2047, 2047);
        push_read(-2048, -2048);
        push_item(2'd3, -1, -1, 24'hFFFFFF, -1, -1, 24'hFFFFFF, -1, -1, 24'hFFFFFF);
        // Counter-clockwise, then the same triangle clockwise at equal depth.
        push_item(KIND_TRI, 2, 2, 100, 9, 3, 200, 4, 8, 300);
        push_item(KIND_TRI, 9, 3, 200, 2, 2, 100, 4, 8, 300);
        push_read(4, 4);
        push_item(KIND_TRI, 1, 1, 5, 4, 4, 5, 7, 7, 5);
        push_item(KIND_TRI, -2048, -10, 0, -2040, -10, 0, -2044, -2048, 0);
        push_item(KIND_TRI, 250, 250, 24'hFFFFFF, 2047, 251, 24'hFFFFFF, 252, 2047, 0);
        push_read(255, 254);
        wait_idle();

        // Tiny screen with zero far depth; huge triangles clamp to a few pixels.
        write_reg(REG_WIDTH, 4);
        write_reg(REG_HEIGHT, 3);
        write_reg(REG_FAR, 0);
        push_item(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        push_item(KIND_TRI, -2048, -2048, 24'hFFFFFF, 2047, -2048, 0, -2048, 2047, 0);
        push_item(KIND_TRI, -2048, -2048, 0, 2047, -2048, 0, -2048, 2047, 0);
        push_read(3, 2);
        push_read(4, 2);
        push_read(0, 3);
        wait_idle();

        // Out-of-range size registers act as one and as the maximum.
        write_reg(REG_WIDTH, 0);
        write_reg(REG_HEIGHT, 9'd511);
        write_reg(REG_FAR, 24'hFFFFFF);
        push_item(KIND_TRI, -2048, 0, 7, 2047, 0, 7, 0, 9, 7);
        push_read(0, 255);
        push_read(1, 0);
        for (int i = 0; i < 40; i++) push_random_item();
        wait_idle();

        write_reg(REG_WIDTH, 9'd256);
        write_reg(REG_HEIGHT, 9'd256);
        write_reg(REG_FAR, $urandom_range(0, 24'hFFFFFF));
        push_item(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 600; i++) push_random_item();
        wait_idle();

        write_reg(REG_WIDTH, $urandom_range(1, 256));
        write_reg(REG_HEIGHT, $urandom_range(1, 256));
        write_reg(REG_FAR, $urandom_range(0, 24'hFFFFFF));
        push_item(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 580; i++) push_random_item();
        wait_idle();

        if (error_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
